>>> rtl/s2g_pkg.sv
// ----------------------------------------------------------------------------
// s2g_pkg
// Shared types, constants and the arctangent table for the slant-to-ground
// range pixel pipeline.
// ----------------------------------------------------------------------------
package s2g_pkg;

  localparam int VECTOR_LENGTH_DEF = 8192;

  localparam int COS_STEPS  = 48;
  localparam int SQRT_STEPS = 50;
  localparam int CORDIC_N   = 50;
  localparam int PIX_STEPS  = 32;

  localparam logic [30:0] SAT_RADIUS_RST     = 31'd1833763072;
  localparam logic [30:0] EARTH_RADIUS_RST   = 31'd1632803072;
  localparam logic [29:0] NEAR_SLANT_RST     = 30'd217600000;
  localparam logic [23:0] SLANT_SPACING_RST  = 24'd2022;
  localparam logic [23:0] GROUND_SPACING_RST = 24'd3200;

  typedef enum logic [2:0] {
    REG_SAT_RADIUS     = 3'd0,
    REG_EARTH_RADIUS   = 3'd1,
    REG_NEAR_SLANT     = 3'd2,
    REG_SLANT_SPACING  = 3'd3,
    REG_GROUND_SPACING = 3'd4
  } reg_idx_e;

  // Control bits that travel with each item down the pipeline.
  typedef struct packed {
    logic valid;
    logic near;
    logic err;
    logic neg;
  } tag_t;

  // Power series of atan(1/m) in Q60, for m = 3 or m = 2^sh.
  function automatic logic [63:0] atan_series(input logic use_three, input int unsigned sh);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] t;
    sum = '0;
    p = use_three ? (64'd1 << 60) / 64'd3 : (64'd1 << 60) >> sh;
    for (int k = 0; k < 40; k++) begin
      if (p != 64'd0) begin
        t = p / 64'(2 * k + 1);
        if ((k & 1) != 0) begin
          sum = sum - t;
        end else begin
          sum = sum + t;
        end
        p = use_three ? p / 64'd9 : p >> (2 * sh);
      end
    end
    return sum;
  endfunction

  // atan(2^-i) in Q48, rounded to nearest.
  function automatic logic [51:0] atan_q48(input int unsigned i);
    logic [63:0] v;
    if (i == 0) begin
      v = atan_series(1'b1, 0) + atan_series(1'b0, 1);
    end else begin
      v = atan_series(1'b0, i);
    end
    return 52'((v + 64'd2048) >> 12);
  endfunction

endpackage

>>> rtl/slant_to_ground_range_pixel.sv
// ----------------------------------------------------------------------------
// slant_to_ground_range_pixel
// Maps a slant-range pixel index to a ground-range position in ground pixels
// (Q16.16) over a spherical Earth, fully pipelined.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                                   Handshake
//  command   in         start_i, busy_o, pixel_index_i            start_i & !busy_o
//  result    out        valid_o, ground_pixel_o, geometry_error_o  strobe, no stall
//  config    in         cfg_we_i, cfg_idx_i, cfg_wdata_i           write on cfg_we_i
//
// One item is accepted per cycle while busy_o is low; each result passes through
// the 48-step cosine divider, the 50-step square root, the 50-step CORDIC
// and the 32-step pixel divider.
// After reset and after every register write, busy_o is high for one cycle
// while the near-edge point is sent down the pipeline to refresh its cache.
// The result side cannot stall, so the pipeline advances every cycle.
// ----------------------------------------------------------------------------
module slant_to_ground_range_pixel #(
  parameter int VectorLength = s2g_pkg::VECTOR_LENGTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [12:0] pixel_index_i,
  output logic        valid_o,
  output logic [31:0] ground_pixel_o,
  output logic        geometry_error_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [30:0] cfg_wdata_i
);

  localparam logic [16:0] VecLen = 17'(VectorLength);
  localparam logic [12:0] IdxMax = 13'(VectorLength - 1);

  // Configuration and values derived from it.
  logic [30:0] sat_q, earth_q;
  logic [29:0] nslant_q;
  logic [23:0] sspace_q, gspace_q;
  logic        cfg_hit;
  logic        pend_q, pend_d;
  logic [61:0] ee_q, ss_q, se_q;
  logic [62:0] sum_q, den_q;

  always_comb begin
    unique case (cfg_idx_i)
      s2g_pkg::REG_SAT_RADIUS,
      s2g_pkg::REG_EARTH_RADIUS,
      s2g_pkg::REG_NEAR_SLANT,
      s2g_pkg::REG_SLANT_SPACING,
      s2g_pkg::REG_GROUND_SPACING: cfg_hit = 1'b1;
      default:                     cfg_hit = 1'b0;
    endcase
  end

  assign pend_d = cfg_we_i & cfg_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q    <= s2g_pkg::SAT_RADIUS_RST;
      earth_q  <= s2g_pkg::EARTH_RADIUS_RST;
      nslant_q <= s2g_pkg::NEAR_SLANT_RST;
      sspace_q <= s2g_pkg::SLANT_SPACING_RST;
      gspace_q <= s2g_pkg::GROUND_SPACING_RST;
      pend_q   <= 1'b1;
    end else begin
      pend_q <= pend_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          s2g_pkg::REG_SAT_RADIUS:     sat_q    <= cfg_wdata_i;
          s2g_pkg::REG_EARTH_RADIUS:   earth_q  <= cfg_wdata_i;
          s2g_pkg::REG_NEAR_SLANT:     nslant_q <= cfg_wdata_i[29:0];
          s2g_pkg::REG_SLANT_SPACING:  sspace_q <= cfg_wdata_i[23:0];
          s2g_pkg::REG_GROUND_SPACING: gspace_q <= cfg_wdata_i[23:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ee_q  <= 62'(earth_q) * 62'(earth_q);
    ss_q  <= 62'(sat_q) * 62'(sat_q);
    se_q  <= 62'(sat_q) * 62'(earth_q);
    sum_q <= 63'(ee_q) + 63'(ss_q);
    den_q <= {se_q, 1'b0};
  end

  assign busy_o = pend_q;

  // Stage A: slant distance. The near-edge point rides in the slot after a write.
  s2g_pkg::tag_t a_tag_q, a_tag_d;
  logic [37:0]   a_slant_q, a_slant_d;
  logic [12:0]   idx_sat;
  logic [36:0]   idx_prod;

  assign idx_sat  = ({4'b0, pixel_index_i} >= VecLen) ? IdxMax : pixel_index_i;
  assign idx_prod = 37'(idx_sat) * 37'(sspace_q);

  always_comb begin
    a_tag_d       = '0;
    a_tag_d.valid = pend_q | start_i;
    a_tag_d.near  = pend_q;
    a_slant_d     = pend_q ? 38'(nslant_q) : 38'(nslant_q) + 38'(idx_prod);
  end

  // Stage B: range check and slant squared.
  s2g_pkg::tag_t b_tag_q, b_tag_d;
  logic [63:0]   b_sq_q;
  logic [31:0]   se_sum;

  assign se_sum = 32'(sat_q) + 32'(earth_q);

  always_comb begin
    b_tag_d     = a_tag_q;
    b_tag_d.err = (sat_q == '0) | (earth_q == '0) | (a_slant_q > 38'(se_sum));
  end

  // Stage C: sign and magnitude of the cosine numerator.
  s2g_pkg::tag_t c_tag_q, c_tag_d;
  logic [63:0]   c_mag_q, c_mag_d;

  always_comb begin
    c_tag_d     = b_tag_q;
    c_tag_d.neg = b_sq_q > 64'(sum_q);
    c_mag_d     = c_tag_d.neg ? b_sq_q - 64'(sum_q) : 64'(sum_q) - b_sq_q;
  end

  // Stage D: cosine out of range, or exactly one.
  s2g_pkg::tag_t d_tag_q, d_tag_d;
  logic [62:0]   d_mag_q;
  logic          d_eq_q;

  always_comb begin
    d_tag_d     = c_tag_q;
    d_tag_d.err = c_tag_q.err | (c_mag_q > {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_tag_q <= '0;
      b_tag_q <= '0;
      c_tag_q <= '0;
      d_tag_q <= '0;
    end else begin
      a_tag_q <= a_tag_d;
      b_tag_q <= b_tag_d;
      c_tag_q <= c_tag_d;
      d_tag_q <= d_tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_slant_q <= a_slant_d;
    b_sq_q    <= 64'(a_slant_q[31:0]) * 64'(a_slant_q[31:0]);
    c_mag_q   <= c_mag_d;
    d_mag_q   <= c_mag_q[62:0];
    d_eq_q    <= c_mag_q == {1'b0, den_q};
  end

  s2g_pkg::tag_t cd_tag;
  logic [48:0]   cd_q;

  s2g_cos_div u_cos_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (d_tag_q),
    .mag_i  (d_mag_q),
    .eq_i   (d_eq_q),
    .den_i  (den_q),
    .tag_o  (cd_tag),
    .q_o    (cd_q)
  );

  // Stages E to G: radicand 1 - c^2 in Q96, squaring by partial products.
  s2g_pkg::tag_t e_tag_q, f_tag_q, g_tag_q;
  logic [48:0]   e_q_q, f_q_q, g_q_q;
  logic [47:0]   e_hh_q;
  logic [48:0]   e_hl_q;
  logic [49:0]   e_ll_q;
  logic [97:0]   f_qsq_q;
  logic [96:0]   g_p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_tag_q <= '0;
      f_tag_q <= '0;
      g_tag_q <= '0;
    end else begin
      e_tag_q <= cd_tag;
      f_tag_q <= e_tag_q;
      g_tag_q <= f_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q_q   <= cd_q;
    e_hh_q  <= 48'(cd_q[48:25]) * 48'(cd_q[48:25]);
    e_hl_q  <= 49'(cd_q[48:25]) * 49'(cd_q[24:0]);
    e_ll_q  <= 50'(cd_q[24:0]) * 50'(cd_q[24:0]);
    f_q_q   <= e_q_q;
    f_qsq_q <= (98'(e_hh_q) << 50) + (98'(e_hl_q) << 26) + 98'(e_ll_q);
    g_q_q   <= f_q_q;
    g_p_q   <= 97'((98'd1 << 96) - f_qsq_q);
  end

  s2g_pkg::tag_t sq_tag;
  logic [48:0]   sq_q;
  logic [49:0]   sq_sn;

  s2g_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (g_tag_q),
    .q_i    (g_q_q),
    .p_i    (g_p_q),
    .tag_o  (sq_tag),
    .q_o    (sq_q),
    .sn_o   (sq_sn)
  );

  s2g_pkg::tag_t co_tag;
  logic [50:0]   co_z;

  s2g_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (sq_tag),
    .q_i    (sq_q),
    .sn_i   (sq_sn),
    .tag_o  (co_tag),
    .z_o    (co_z)
  );

  // Stages H and I: ground distance R * angle, split in two partial products.
  s2g_pkg::tag_t h_tag_q, i_tag_q;
  logic [55:0]   h_p1_q;
  logic [56:0]   h_p0_q;
  logic [39:0]   i_g_q;
  logic [81:0]   h_sum;

  assign h_sum = (82'(h_p1_q) << 26) + 82'(h_p0_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_tag_q <= '0;
      i_tag_q <= '0;
    end else begin
      h_tag_q <= co_tag;
      i_tag_q <= h_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    h_p1_q <= 56'(earth_q) * 56'(co_z[50:26]);
    h_p0_q <= 57'(earth_q) * 57'(co_z[25:0]);
    i_g_q  <= h_sum[80:41];
  end

  // Stage J: near-edge cache and difference. The near point leaves no result.
  s2g_pkg::tag_t j_tag_q, j_tag_d;
  logic [48:0]   j_num_q;
  logic [39:0]   near_g_q;
  logic          near_bad_q;
  logic [39:0]   diff;

  assign diff = (i_g_q > near_g_q) ? i_g_q - near_g_q : '0;

  always_comb begin
    j_tag_d       = i_tag_q;
    j_tag_d.valid = i_tag_q.valid & ~i_tag_q.near;
    j_tag_d.err   = i_tag_q.err | near_bad_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_tag_q    <= '0;
      near_g_q   <= '0;
      near_bad_q <= 1'b0;
    end else begin
      j_tag_q <= j_tag_d;
      if (i_tag_q.valid && i_tag_q.near) begin
        near_g_q   <= i_g_q;
        near_bad_q <= i_tag_q.err;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    j_num_q <= {diff, 9'b0};
  end

  s2g_pkg::tag_t pd_tag;
  logic [31:0]   pd_pix;

  s2g_pix_div u_pix_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (j_tag_q),
    .num_i  (j_num_q),
    .gs_i   (gspace_q),
    .tag_o  (pd_tag),
    .pix_o  (pd_pix)
  );

  logic        out_valid_q;
  logic [31:0] out_pix_q;
  logic        out_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= pd_tag.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_pix_q <= pd_pix;
    out_err_q <= pd_tag.err;
  end

  assign valid_o          = out_valid_q;
  assign ground_pixel_o   = out_pix_q;
  assign geometry_error_o = out_err_q;

  // A flagged item carries a zero position.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && geometry_error_o |-> ground_pixel_o == '0)
    else $error("flagged item with nonzero ground position");

  // A write to a register refreshes the near-edge cache.
  a_cfg_refresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i <= 3'(s2g_pkg::REG_GROUND_SPACING)) |=> busy_o)
    else $error("register write did not start a near-edge refresh");

  // The refresh slot lasts one cycle unless another write comes in.
  a_busy_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o && !cfg_we_i |=> !busy_o)
    else $error("busy held without a register write");

endmodule

>>> rtl/s2g_cos_div.sv
// ----------------------------------------------------------------------------
// s2g_cos_div
// Pipelined restoring divider giving the cosine magnitude mag/den in Q48,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module s2g_cos_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  s2g_pkg::tag_t   tag_i,
  input  logic [62:0]     mag_i,
  input  logic            eq_i,
  input  logic [62:0]     den_i,
  output s2g_pkg::tag_t   tag_o,
  output logic [48:0]     q_o
);

  localparam int N = s2g_pkg::COS_STEPS;

  s2g_pkg::tag_t tag_q [N];
  logic [62:0]   r_q   [N];
  logic [47:0]   q_q   [N];
  logic          eq_q  [N];

  for (genvar g = 0; g < N; g++) begin : g_step
    s2g_pkg::tag_t tin;
    logic [62:0]   rin;
    logic [47:0]   qin;
    logic          eqin;
    logic [63:0]   sh;
    logic          ge;

    if (g == 0) begin : g_first
      assign tin  = tag_i;
      assign rin  = mag_i;
      assign qin  = '0;
      assign eqin = eq_i;
    end else begin : g_next
      assign tin  = tag_q[g-1];
      assign rin  = r_q[g-1];
      assign qin  = q_q[g-1];
      assign eqin = eq_q[g-1];
    end

    assign sh = {rin, 1'b0};
    assign ge = sh >= {1'b0, den_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[g] <= '0;
      end else begin
        tag_q[g] <= tin;
      end
    end

    always_ff @(posedge clk_i) begin
      r_q[g]  <= ge ? 63'(sh - {1'b0, den_i}) : sh[62:0];
      q_q[g]  <= {qin[46:0], ge};
      eq_q[g] <= eqin;
    end
  end

  assign tag_o = tag_q[N-1];
  // A magnitude equal to the denominator is a cosine of exactly one.
  assign q_o   = eq_q[N-1] ? (49'd1 << 48) : {1'b0, q_q[N-1]};

endmodule

>>> rtl/s2g_sqrt.sv
// ----------------------------------------------------------------------------
// s2g_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage,
// giving the sine in Q48.
// ----------------------------------------------------------------------------
module s2g_sqrt (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  s2g_pkg::tag_t   tag_i,
  input  logic [48:0]     q_i,
  input  logic [96:0]     p_i,
  output s2g_pkg::tag_t   tag_o,
  output logic [48:0]     q_o,
  output logic [49:0]     sn_o
);

  localparam int N = s2g_pkg::SQRT_STEPS;

  s2g_pkg::tag_t tag_q  [N];
  logic [99:0]   p_q    [N];
  logic [48:0]   q_q    [N];
  logic [49:0]   root_q [N];
  logic [53:0]   rem_q  [N];

  for (genvar g = 0; g < N; g++) begin : g_step
    localparam int K = N - 1 - g;
    s2g_pkg::tag_t tin;
    logic [99:0]   pin;
    logic [48:0]   qin;
    logic [49:0]   rootin;
    logic [53:0]   remin;
    logic [53:0]   rs;
    logic [53:0]   trial;
    logic          ge;

    if (g == 0) begin : g_first
      assign tin    = tag_i;
      assign pin    = {3'b0, p_i};
      assign qin    = q_i;
      assign rootin = '0;
      assign remin  = '0;
    end else begin : g_next
      assign tin    = tag_q[g-1];
      assign pin    = p_q[g-1];
      assign qin    = q_q[g-1];
      assign rootin = root_q[g-1];
      assign remin  = rem_q[g-1];
    end

    assign rs    = {remin[51:0], pin[2*K+1 -: 2]};
    assign trial = {2'b0, rootin, 2'b01};
    assign ge    = rs >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[g] <= '0;
      end else begin
        tag_q[g] <= tin;
      end
    end

    always_ff @(posedge clk_i) begin
      p_q[g]    <= pin;
      q_q[g]    <= qin;
      rem_q[g]  <= ge ? rs - trial : rs;
      root_q[g] <= {rootin[48:0], ge};
    end
  end

  assign tag_o = tag_q[N-1];
  assign q_o   = q_q[N-1];
  assign sn_o  = root_q[N-1];

endmodule

>>> rtl/s2g_cordic.sv
// ----------------------------------------------------------------------------
// s2g_cordic
// Pipelined vectoring CORDIC turning (cos, sin) into an angle in Q48 rad,
// one iteration per stage.
// ----------------------------------------------------------------------------
module s2g_cordic (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  s2g_pkg::tag_t   tag_i,
  input  logic [48:0]     q_i,
  input  logic [49:0]     sn_i,
  output s2g_pkg::tag_t   tag_o,
  output logic [50:0]     z_o
);

  localparam int N = s2g_pkg::CORDIC_N;
  localparam logic signed [51:0] HalfPi = signed'(s2g_pkg::atan_q48(0) << 1);

  s2g_pkg::tag_t      tag_q [N];
  logic signed [51:0] x_q   [N];
  logic signed [51:0] y_q   [N];
  logic signed [51:0] z_q   [N];

  logic signed [51:0] x0;
  logic signed [51:0] y0;
  logic signed [51:0] z0;

  // A negative cosine starts from the vector turned by a quarter circle.
  assign x0 = tag_i.neg ? signed'({2'b0, sn_i}) : signed'({3'b0, q_i});
  assign y0 = tag_i.neg ? signed'({3'b0, q_i}) : signed'({2'b0, sn_i});
  assign z0 = tag_i.neg ? HalfPi : '0;

  for (genvar g = 0; g < N; g++) begin : g_step
    localparam logic signed [51:0] At = signed'(s2g_pkg::atan_q48(g));
    s2g_pkg::tag_t      tin;
    logic signed [51:0] xin;
    logic signed [51:0] yin;
    logic signed [51:0] zin;
    logic               up;

    if (g == 0) begin : g_first
      assign tin = tag_i;
      assign xin = x0;
      assign yin = y0;
      assign zin = z0;
    end else begin : g_next
      assign tin = tag_q[g-1];
      assign xin = x_q[g-1];
      assign yin = y_q[g-1];
      assign zin = z_q[g-1];
    end

    assign up = yin > 52'sd0;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[g] <= '0;
      end else begin
        tag_q[g] <= tin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (up) begin
        x_q[g] <= xin + (yin >>> g);
        y_q[g] <= yin - (xin >>> g);
        z_q[g] <= zin + At;
      end else begin
        x_q[g] <= xin - (yin >>> g);
        y_q[g] <= yin + (xin >>> g);
        z_q[g] <= zin - At;
      end
    end
  end

  assign tag_o = tag_q[N-1];
  assign z_o   = z_q[N-1][51] ? '0 : z_q[N-1][50:0];

endmodule

>>> rtl/s2g_pix_div.sv
// ----------------------------------------------------------------------------
// s2g_pix_div
// Pipelined division of the ground distance by the ground pixel spacing,
// with saturation to 32 bits found up front.
// ----------------------------------------------------------------------------
module s2g_pix_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  s2g_pkg::tag_t   tag_i,
  input  logic [48:0]     num_i,
  input  logic [23:0]     gs_i,
  output s2g_pkg::tag_t   tag_o,
  output logic [31:0]     pix_o
);

  localparam int N = s2g_pkg::PIX_STEPS;

  s2g_pkg::tag_t s0_tag_q;
  logic [48:0]   s0_rem_q;
  logic          s0_sat_q;

  s2g_pkg::tag_t tag_q [N];
  logic [48:0]   rem_q [N];
  logic [31:0]   q_q   [N];
  logic          sat_q [N];

  // A quotient that needs more than 32 bits saturates; a zero spacing does too.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_tag_q <= '0;
    end else begin
      s0_tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_rem_q <= num_i;
    s0_sat_q <= {7'b0, num_i} >= {gs_i, 32'h0};
  end

  for (genvar g = 0; g < N; g++) begin : g_step
    localparam int K = N - 1 - g;
    s2g_pkg::tag_t tin;
    logic [48:0]   rin;
    logic [31:0]   qin;
    logic          satin;
    logic [55:0]   trial;
    logic          ge;

    if (g == 0) begin : g_first
      assign tin   = s0_tag_q;
      assign rin   = s0_rem_q;
      assign qin   = '0;
      assign satin = s0_sat_q;
    end else begin : g_next
      assign tin   = tag_q[g-1];
      assign rin   = rem_q[g-1];
      assign qin   = q_q[g-1];
      assign satin = sat_q[g-1];
    end

    assign trial = 56'(gs_i) << K;
    assign ge    = 56'(rin) >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[g] <= '0;
      end else begin
        tag_q[g] <= tin;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[g] <= ge ? 49'(56'(rin) - trial) : rin;
      q_q[g]   <= {qin[30:0], ge};
      sat_q[g] <= satin;
    end
  end

  assign tag_o = tag_q[N-1];

  always_comb begin
    priority if (tag_q[N-1].err) begin
      pix_o = '0;
    end else if (sat_q[N-1]) begin
      pix_o = '1;
    end else begin
      pix_o = q_q[N-1];
    end
  end

endmodule
